### hdl/mpfb_pkg.sv
// Package: shared types and constants for the max pool forward/backward block.
`default_nettype none
package mpfb_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD_RD,
        ST_BWD_MAX,
        ST_BWD_EMIT
    } state_t;
endpackage
`default_nettype wire

### hdl/max_pool_forward_backward.sv
// Top level: max pooling, forward and backward, with sample and maximum memories.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata = sample[15:0]; s_tuser = operation
//  m_      | out | m_tvalid/m_tready  | m_tdata = value,row,column,channel; m_tuser = is_gradient
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Forward word: partial-max memory read at accept, then write back; a word that
// completes a window holds the input until the pooled word is taken.
// Backward word: window maximum read at accept, then for each of the
// pool_size^2 gradients a sample memory read, then an output load.
// One word is in flight at a time; m_tvalid holds while m_tready is low.
// Reset (aresetn low, synchronous) clears positions and control; memories
// are undefined until written.
`default_nettype none
module max_pool_forward_backward #(
    parameter int MAX_HEIGHT = 32,
    parameter int MAX_WIDTH = 32,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_POOL = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [15:0] s_tdata,  // sample[15:0]
    input  wire logic s_tuser,         // operation
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [31:0] m_tdata,       // value[15:0] row[20:16] column[25:21] channel[29:26]
                                       // zero[31:30]
    output logic      m_tuser,         // is_gradient
    output logic      m_tlast,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [mpfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import mpfb_pkg::*;

    localparam int HW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_CHANNELS) > 0 ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW = HW + WW + CW;
    localparam int PW = WW + CW;
    localparam int KW = $clog2(MAX_POOL + 1);

    // configuration
    logic [2:0] pool_reg;
    logic [5:0] height_reg, width_reg;
    logic [4:0] chan_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= 3'd2; height_reg <= 6'd28; width_reg <= 6'd28; chan_reg <= 5'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POOL_SIZE:     pool_reg <= cfg_data[2:0];
                REG_MAP_HEIGHT:    height_reg <= cfg_data[5:0];
                REG_MAP_WIDTH:     width_reg <= cfg_data[5:0];
                REG_CHANNEL_COUNT: chan_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [8:0] p, h, w, nch;
    always_comb begin
        p = (pool_reg == 3'd0) ? 9'd1 : ({6'd0, pool_reg} > 9'(MAX_POOL) ? 9'(MAX_POOL)
                                                            : {6'd0, pool_reg});
        h = (height_reg == 6'd0) ? 9'd1 : ({3'd0, height_reg} > 9'(MAX_HEIGHT)
                                          ? 9'(MAX_HEIGHT) : {3'd0, height_reg});
        w = (width_reg == 6'd0) ? 9'd1 : ({3'd0, width_reg} > 9'(MAX_WIDTH)
                                         ? 9'(MAX_WIDTH) : {3'd0, width_reg});
        nch = (chan_reg == 5'd0) ? 9'd1 : ({4'd0, chan_reg} > 9'(MAX_CHANNELS)
                                          ? 9'(MAX_CHANNELS) : {4'd0, chan_reg});
    end

    // quotient by the pool size (1..7) through reciprocal multiply;
    // exact for dividends below 64, which covers sizes and positions
    function automatic logic [8:0] div_p(input logic [8:0] n, input logic [8:0] d);
        logic [17:0] prod;
        logic [8:0] q;
        prod = '0;
        case (d)
            9'd1: q = n;
            9'd2: q = {1'b0, n[8:1]};
            9'd3: begin prod = 18'(n) * 18'd43;  q = 9'(prod >> 7);  end
            9'd4: q = {2'b0, n[8:2]};
            9'd5: begin prod = 18'(n) * 18'd205; q = 9'(prod >> 10); end
            9'd6: begin prod = 18'(n) * 18'd43;  q = 9'(prod >> 8);  end
            9'd7: begin prod = 18'(n) * 18'd37;  q = 9'(prod >> 8);  end
            9'd8: q = {3'b0, n[8:3]};
            default: q = n;
        endcase
        return q;
    endfunction

    // memories
    logic signed [DATA_WIDTH-1:0] in_mem [2**AW];
    logic signed [DATA_WIDTH-1:0] max_mem [2**AW];
    logic signed [DATA_WIDTH-1:0] pm_mem [2**PW];

    state_t state_reg, state_next;
    logic [HW-1:0] in_row_reg; logic [WW-1:0] in_col_reg; logic [CW-1:0] in_chan_reg;
    logic [HW-1:0] g_row_reg;  logic [WW-1:0] g_col_reg;  logic [CW-1:0] g_chan_reg;
    logic [KW-1:0] kh_reg, kw_reg;
    logic signed [DATA_WIDTH-1:0] sample_reg, pm_rd_reg, max_rd_reg, in_rd_reg;
    logic first_reg, emit_reg, inwin_reg;
    logic [PW-1:0] pi_reg;
    logic [AW-1:0] addr_reg;

    // output map size, forward window index and phase within the window
    logic [8:0] oh, ow, qr, qc, phr, phc;
    always_comb begin
        oh = div_p(h, p);
        ow = div_p(w, p);
        qr = div_p(9'(in_row_reg), p);
        qc = div_p(9'(in_col_reg), p);
        phr = 9'(in_row_reg) - qr * p;
        phc = 9'(in_col_reg) - qc * p;
    end

    logic acc;
    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;
    assign acc = s_tvalid && s_tready;

    // backward wrapped position
    logic [HW-1:0] gr; logic [WW-1:0] gc; logic [CW-1:0] gch;
    always_comb begin
        gr  = (9'(g_row_reg) >= oh) ? '0 : g_row_reg;
        gc  = (9'(g_col_reg) >= ow) ? '0 : g_col_reg;
        gch = (9'(g_chan_reg) >= nch) ? '0 : g_chan_reg;
    end

    logic [8:0] br, bc;
    assign br = 9'(gr) * p + 9'(kh_reg);
    assign bc = 9'(gc) * p + 9'(kw_reg);

    // sample read runs one gradient ahead: at a handshake it fetches the next offset
    logic [KW-1:0] rd_kh, rd_kw;
    always_comb begin
        rd_kh = kh_reg;
        rd_kw = kw_reg;
        if (state_reg == ST_BWD_EMIT) begin
            if (9'(kw_reg) + 9'd1 >= p) begin
                rd_kw = '0;
                rd_kh = kh_reg + 1'b1;
            end else rd_kw = kw_reg + 1'b1;
        end
    end
    logic [8:0] rd_row, rd_col;
    assign rd_row = 9'(gr) * p + 9'(rd_kh);
    assign rd_col = 9'(gc) * p + 9'(rd_kw);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    logic bwd_done;
    assign bwd_done = (9'(kh_reg) == p - 9'd1) && (9'(kw_reg) == p - 9'd1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (acc) begin
                if (!s_tuser) state_next = ST_FWD_RD;
                else if (oh != 9'd0 && ow != 9'd0) state_next = ST_BWD_MAX;
            end
            ST_FWD_RD: state_next = ST_IDLE;
            ST_BWD_MAX: state_next = ST_BWD_EMIT;
            ST_BWD_EMIT: if (m_tvalid && m_tready && m_tlast) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // memory ports
    logic signed [DATA_WIDTH-1:0] new_max;
    assign new_max = (first_reg || sample_reg > pm_rd_reg) ? sample_reg : pm_rd_reg;
    logic [AW-1:0] rd_addr;
    assign rd_addr = {rd_row[HW-1:0], rd_col[WW-1:0], gch};

    always_ff @(posedge aclk) begin
        if (acc && !s_tuser) in_mem[{in_row_reg, in_col_reg, in_chan_reg}] <= s_tdata;
        if (acc) pm_rd_reg <= pm_mem[{qc[WW-1:0], in_chan_reg}];
        if (state_reg == ST_FWD_RD && inwin_reg) pm_mem[pi_reg] <= new_max;
        if (state_reg == ST_FWD_RD && emit_reg) max_mem[addr_reg] <= new_max;
        if (acc) max_rd_reg <= max_mem[{gr, gc, gch}];
        if (state_reg == ST_BWD_MAX || (state_reg == ST_BWD_EMIT && m_tvalid && m_tready))
            in_rd_reg <= in_mem[rd_addr];
    end

    // control and positions
    logic emit_ld;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg <= '0; in_col_reg <= '0; in_chan_reg <= '0;
            g_row_reg <= '0; g_col_reg <= '0; g_chan_reg <= '0;
            kh_reg <= '0; kw_reg <= '0; m_tvalid <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (acc && !s_tuser) begin
                sample_reg <= s_tdata;
                first_reg <= (phr == 9'd0) && (phc == 9'd0);
                inwin_reg <= (9'(in_row_reg) < oh * p) && (9'(in_col_reg) < ow * p)
                             && (9'(in_chan_reg) < nch);
                emit_reg  <= (9'(in_row_reg) < oh * p) && (9'(in_col_reg) < ow * p)
                             && (9'(in_chan_reg) < nch)
                             && (phr == p - 9'd1) && (phc == p - 9'd1);
                pi_reg <= {qc[WW-1:0], in_chan_reg};
                addr_reg <= {qr[HW-1:0], qc[WW-1:0], in_chan_reg};
                // advance forward position
                if (9'(in_chan_reg) + 9'd1 >= nch) begin
                    in_chan_reg <= '0;
                    if (9'(in_col_reg) + 9'd1 >= w) begin
                        in_col_reg <= '0;
                        if (9'(in_row_reg) + 9'd1 >= h) in_row_reg <= '0;
                        else in_row_reg <= in_row_reg + 1'b1;
                    end else in_col_reg <= in_col_reg + 1'b1;
                end else in_chan_reg <= in_chan_reg + 1'b1;
            end
            if (acc && s_tuser) begin
                sample_reg <= s_tdata;
                kh_reg <= '0; kw_reg <= '0;
                if (oh != 9'd0 && ow != 9'd0) begin
                    g_row_reg <= gr; g_col_reg <= gc; g_chan_reg <= gch;
                end
            end
            if (state_reg == ST_FWD_RD && emit_reg) m_tvalid <= 1'b1;
            if (emit_ld) begin
                m_tvalid <= 1'b1;
            end
            if (state_reg == ST_BWD_EMIT && m_tvalid && m_tready) begin
                if (m_tlast) begin
                    // advance backward position
                    if (9'(g_chan_reg) + 9'd1 >= nch) begin
                        g_chan_reg <= '0;
                        if (9'(g_col_reg) + 9'd1 >= ow) begin
                            g_col_reg <= '0;
                            g_row_reg <= (9'(g_row_reg) + 9'd1 >= oh) ? '0
                                                                   : g_row_reg + 1'b1;
                        end else g_col_reg <= g_col_reg + 1'b1;
                    end else g_chan_reg <= g_chan_reg + 1'b1;
                end else begin
                    kh_reg <= rd_kh;
                    kw_reg <= rd_kw;
                end
            end
        end
    end

    // backward emission: a gradient is loaded when the sample memory read lands
    logic pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) pend_reg <= 1'b0;
        else pend_reg <= (state_reg == ST_BWD_MAX) ||
                         (state_reg == ST_BWD_EMIT && m_tvalid && m_tready && !m_tlast);
    end
    assign emit_ld = pend_reg && state_reg == ST_BWD_EMIT;

    logic [15:0] val_reg; logic [4:0] row_reg, col_reg; logic [3:0] ch_reg;
    logic grad_reg, last_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FWD_RD) begin
            val_reg <= 16'(new_max);
            row_reg <= 5'(addr_reg[AW-1 -: HW]);
            col_reg <= 5'(addr_reg[CW +: WW]);
            ch_reg <= 4'(addr_reg[CW-1:0]);
            grad_reg <= 1'b0; last_reg <= 1'b1;
        end else if (emit_ld) begin
            val_reg <= (in_rd_reg == max_rd_reg) ? 16'(sample_reg) : 16'd0;
            row_reg <= 5'(br); col_reg <= 5'(bc); ch_reg <= 4'(gch);
            grad_reg <= 1'b1; last_reg <= bwd_done;
        end
    end
    assign m_tdata = {2'b00, ch_reg, col_reg, row_reg, val_reg};
    assign m_tuser = grad_reg;
    assign m_tlast = last_reg;
endmodule
`default_nettype wire
